@@ hdl/mtr_pkg.sv @@
// Shared types, register offsets and function codes of the multicore timer block.
`default_nettype none

package mtr_pkg;

  localparam int NumLocalDef = 4;
  localparam int LocalIrqW   = 4;

  // Function codes of a request
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;

  // Global register map
  localparam logic [10:0] AddrCntLo   = 11'h100;
  localparam logic [10:0] AddrCntHi   = 11'h104;
  localparam logic [10:0] AddrCntWs   = 11'h110;
  localparam logic [10:0] AddrCmpLo   = 11'h200;
  localparam logic [10:0] AddrCmpHi   = 11'h204;
  localparam logic [10:0] AddrStep    = 11'h208;
  localparam logic [10:0] AddrCtl     = 11'h240;
  localparam logic [10:0] AddrIstat   = 11'h244;
  localparam logic [10:0] AddrIen     = 11'h248;
  localparam logic [10:0] AddrWs      = 11'h24C;
  localparam logic [10:0] AddrLocBase = 11'h300;

  // Local timer register offsets within its 0x100 page
  localparam logic [7:0] OffPreload = 8'h00;
  localparam logic [7:0] OffPleft   = 8'h04;
  localparam logic [7:0] OffIreload = 8'h08;
  localparam logic [7:0] OffIleft   = 8'h0C;
  localparam logic [7:0] OffCtl     = 8'h20;
  localparam logic [7:0] OffStat    = 8'h30;
  localparam logic [7:0] OffIen     = 8'h34;
  localparam logic [7:0] OffWs      = 8'h40;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] addr;
    logic [31:0] wdata;
  } mtr_req_t;

  typedef struct packed {
    logic [31:0]          rdata;
    logic                 global_irq;
    logic [LocalIrqW-1:0] local_irq;
  } mtr_rsp_t;

  // Decoded request as seen by the register banks
  typedef struct packed {
    logic        tick;
    logic        rd;
    logic        wr;
    logic [10:0] addr;
    logic [31:0] wdata;
  } mtr_acc_t;

endpackage

`default_nettype wire

@@ hdl/mtr_global.sv @@
// Global free-running counter, comparator and their registers.
`default_nettype none

module mtr_global (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mtr_pkg::mtr_acc_t acc_i,
  input  wire logic              sel_i,
  output logic [31:0]            rdata_o,
  output logic                   irq_o
);

  logic [63:0] cnt_q, cnt_d;
  logic [63:0] cmp_q, cmp_d;
  logic [31:0] step_q, step_d;
  logic        ctl_en_q, ctl_en_d;
  logic        ctl_auto_q, ctl_auto_d;
  logic        ctl_start_q, ctl_start_d;
  logic        stat_q, stat_d;
  logic        ien_q, ien_d;
  logic [2:0]  ws_q, ws_d;
  logic        ws_ctl_q, ws_ctl_d;
  logic [1:0]  ws_cnt_q, ws_cnt_d;

  logic        wr, rd, run, hit;
  logic [63:0] cnt_inc;
  logic [31:0] w;

  assign wr      = acc_i.wr & sel_i;
  assign rd      = acc_i.rd & sel_i;
  assign w       = acc_i.wdata;
  assign run     = acc_i.tick & ctl_start_q;
  assign cnt_inc = cnt_q + 64'd1;
  // comparator looks at the counter after it has advanced
  assign hit     = run & ctl_en_q & (cnt_inc == cmp_q);

  always_comb begin
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    step_d      = step_q;
    ctl_en_d    = ctl_en_q;
    ctl_auto_d  = ctl_auto_q;
    ctl_start_d = ctl_start_q;
    stat_d      = stat_q;
    ien_d       = ien_q;
    ws_d        = ws_q;
    ws_ctl_d    = ws_ctl_q;
    ws_cnt_d    = ws_cnt_q;

    if (run) begin
      cnt_d = cnt_inc;
    end
    if (hit) begin
      stat_d = 1'b1;
      if (ctl_auto_q) begin
        cmp_d = cmp_q + {32'd0, step_q};
      end
    end

    if (wr) begin
      unique case (acc_i.addr)
        mtr_pkg::AddrCntLo: begin
          cnt_d       = {cnt_q[63:32], w};
          ws_cnt_d[0] = 1'b1;
        end
        mtr_pkg::AddrCntHi: begin
          cnt_d       = {w, cnt_q[31:0]};
          ws_cnt_d[1] = 1'b1;
        end
        mtr_pkg::AddrCntWs: ws_cnt_d = ws_cnt_q & ~w[1:0];
        mtr_pkg::AddrCmpLo: begin
          cmp_d   = {cmp_q[63:32], w};
          ws_d[0] = 1'b1;
        end
        mtr_pkg::AddrCmpHi: begin
          cmp_d   = {w, cmp_q[31:0]};
          ws_d[1] = 1'b1;
        end
        mtr_pkg::AddrStep: begin
          step_d  = w;
          ws_d[2] = 1'b1;
        end
        mtr_pkg::AddrCtl: begin
          ctl_en_d    = w[0];
          ctl_auto_d  = w[1];
          ctl_start_d = w[8];
          ws_ctl_d    = 1'b1;
        end
        mtr_pkg::AddrIstat: stat_d = stat_q & ~w[0];
        mtr_pkg::AddrIen:   ien_d  = w[0];
        mtr_pkg::AddrWs: begin
          ws_d     = ws_q & ~w[2:0];
          ws_ctl_d = ws_ctl_q & ~w[16];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata_o = '0;
    if (rd) begin
      unique case (acc_i.addr)
        mtr_pkg::AddrCntLo: rdata_o = cnt_q[31:0];
        mtr_pkg::AddrCntHi: rdata_o = cnt_q[63:32];
        mtr_pkg::AddrCntWs: rdata_o = {30'd0, ws_cnt_q};
        mtr_pkg::AddrCmpLo: rdata_o = cmp_q[31:0];
        mtr_pkg::AddrCmpHi: rdata_o = cmp_q[63:32];
        mtr_pkg::AddrStep:  rdata_o = step_q;
        mtr_pkg::AddrCtl:   rdata_o = {23'd0, ctl_start_q, 6'd0, ctl_auto_q, ctl_en_q};
        mtr_pkg::AddrIstat: rdata_o = {31'd0, stat_q};
        mtr_pkg::AddrIen:   rdata_o = {31'd0, ien_q};
        mtr_pkg::AddrWs:    rdata_o = {15'd0, ws_ctl_q, 13'd0, ws_q};
        default:            rdata_o = '0;
      endcase
    end
  end

  // interrupt reflects the state left behind by this request
  assign irq_o = stat_d & ien_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cmp_q       <= '0;
      step_q      <= '0;
      ctl_en_q    <= 1'b0;
      ctl_auto_q  <= 1'b0;
      ctl_start_q <= 1'b0;
      stat_q      <= 1'b0;
      ien_q       <= 1'b0;
      ws_q        <= '0;
      ws_ctl_q    <= 1'b0;
      ws_cnt_q    <= '0;
    end else begin
      cnt_q       <= cnt_d;
      cmp_q       <= cmp_d;
      step_q      <= step_d;
      ctl_en_q    <= ctl_en_d;
      ctl_auto_q  <= ctl_auto_d;
      ctl_start_q <= ctl_start_d;
      stat_q      <= stat_d;
      ien_q       <= ien_d;
      ws_q        <= ws_d;
      ws_ctl_q    <= ws_ctl_d;
      ws_cnt_q    <= ws_cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mtr_local.sv @@
// One local tick timer: prescaler, interrupt period counter and its registers.
`default_nettype none

module mtr_local (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mtr_pkg::mtr_acc_t acc_i,
  input  wire logic              sel_i,
  output logic [31:0]            rdata_o,
  output logic                   irq_o
);

  logic [31:0] pre_rl_q, pre_rl_d;
  logic [30:0] int_rl_q, int_rl_d;
  logic [31:0] pre_left_q, pre_left_d;
  logic [30:0] int_left_q, int_left_d;
  logic        tstart_q, tstart_d;
  logic        istart_q, istart_d;
  logic        interval_q, interval_d;
  logic        stat_q, stat_d;
  logic        ien_q, ien_d;
  logic [2:0]  ws_q, ws_d;   // bit 2 holds the control write status (register bit 3)

  logic        wr, rd;
  logic [7:0]  off;
  logic [31:0] w;

  assign wr  = acc_i.wr & sel_i;
  assign rd  = acc_i.rd & sel_i;
  assign off = acc_i.addr[7:0];
  assign w   = acc_i.wdata;

  always_comb begin
    pre_rl_d   = pre_rl_q;
    int_rl_d   = int_rl_q;
    pre_left_d = pre_left_q;
    int_left_d = int_left_q;
    tstart_d   = tstart_q;
    istart_d   = istart_q;
    interval_d = interval_q;
    stat_d     = stat_q;
    ien_d      = ien_q;
    ws_d       = ws_q;

    if (acc_i.tick && tstart_q) begin
      if (pre_left_q != '0) begin
        pre_left_d = pre_left_q - 32'd1;
      end else begin
        // prescaler wrap: one local event
        pre_left_d = pre_rl_q;
        if (istart_q) begin
          if (int_left_q == '0) begin
            stat_d = 1'b1;
            if (interval_q) begin
              int_left_d = int_rl_q;
            end else begin
              istart_d = 1'b0;
            end
          end else begin
            int_left_d = int_left_q - 31'd1;
          end
        end
      end
    end

    if (wr) begin
      unique case (off)
        mtr_pkg::OffPreload: begin
          pre_rl_d = w;
          ws_d[0]  = 1'b1;
        end
        mtr_pkg::OffIreload: begin
          int_rl_d = w[30:0];
          if (w[31]) begin
            int_left_d = w[30:0];
          end
          ws_d[1] = 1'b1;
        end
        mtr_pkg::OffCtl: begin
          // rising start bits load their counters
          if (w[0] && !tstart_q) begin
            pre_left_d = pre_rl_q;
          end
          if (w[1] && !istart_q) begin
            int_left_d = int_rl_q;
          end
          tstart_d   = w[0];
          istart_d   = w[1];
          interval_d = w[2];
          ws_d[2]    = 1'b1;
        end
        mtr_pkg::OffStat: stat_d = stat_q & ~w[0];
        mtr_pkg::OffIen:  ien_d  = w[0];
        mtr_pkg::OffWs:   ws_d   = ws_q & ~{w[3], w[1], w[0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    rdata_o = '0;
    if (rd) begin
      unique case (off)
        mtr_pkg::OffPreload: rdata_o = pre_rl_q;
        mtr_pkg::OffPleft:   rdata_o = pre_left_q;
        mtr_pkg::OffIreload: rdata_o = {1'b0, int_rl_q};
        mtr_pkg::OffIleft:   rdata_o = {1'b0, int_left_q};
        mtr_pkg::OffCtl:     rdata_o = {29'd0, interval_q, istart_q, tstart_q};
        mtr_pkg::OffStat:    rdata_o = {31'd0, stat_q};
        mtr_pkg::OffIen:     rdata_o = {31'd0, ien_q};
        mtr_pkg::OffWs:      rdata_o = {28'd0, ws_q[2], 1'b0, ws_q[1:0]};
        default:             rdata_o = '0;
      endcase
    end
  end

  assign irq_o = stat_d & ien_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_rl_q   <= '0;
      int_rl_q   <= '0;
      pre_left_q <= '0;
      int_left_q <= '0;
      tstart_q   <= 1'b0;
      istart_q   <= 1'b0;
      interval_q <= 1'b0;
      stat_q     <= 1'b0;
      ien_q      <= 1'b0;
      ws_q       <= '0;
    end else begin
      pre_rl_q   <= pre_rl_d;
      int_rl_q   <= int_rl_d;
      pre_left_q <= pre_left_d;
      int_left_q <= int_left_d;
      tstart_q   <= tstart_d;
      istart_q   <= istart_d;
      interval_q <= interval_d;
      stat_q     <= stat_d;
      ien_q      <= ien_d;
      ws_q       <= ws_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/multicore_timer_registers.sv @@
// Multicore timer top level: request register, register banks and response register.
// Usage:
//   Requests arrive on in_req_i (func, addr, wdata) with in_valid_i/in_ready_o.
//   func selects a timer tick, a register read or a register write; the two low
//   address bits are ignored. Every request gives exactly one response on
//   out_rsp_o with out_valid_o/out_ready_i: read data (zero unless a mapped read)
//   and the global and local interrupt lines as left by that request.
//   The request sits in the request register until the response register is
//   free; then the register banks update and the response register loads.
//   Throughput is one request per cycle while responses are taken; the 64-bit
//   counter and comparator update as each request advances.
//   A response that is not taken holds the response register; the request
//   register keeps accepting until it too is full, so at most two requests are
//   in flight and in_ready_o drops only while both stages are stalled.
//   Reset clears every timer register, status bit and both pipeline stages;
//   the block accepts requests as soon as reset is released.
`default_nettype none

module multicore_timer_registers #(
  parameter int NUM_LOCAL = mtr_pkg::NumLocalDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mtr_pkg::mtr_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mtr_pkg::mtr_rsp_t      out_rsp_o
);

  logic              req_valid_q;
  mtr_pkg::mtr_req_t req_q;
  logic              out_valid_q;
  mtr_pkg::mtr_rsp_t out_q;

  logic              advance;
  mtr_pkg::mtr_acc_t acc;
  mtr_pkg::mtr_rsp_t rsp;
  logic              glob_sel;
  logic [31:0]       glob_rdata;
  logic              glob_irq;
  logic [31:0]       loc_rdata [NUM_LOCAL];
  logic [NUM_LOCAL-1:0] loc_irq;
  logic [NUM_LOCAL-1:0] loc_sel;
  logic [mtr_pkg::LocalIrqW-1:0] loc_irq_all;

  assign advance    = req_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~req_valid_q | advance;

  assign acc.tick  = advance & (req_q.func == mtr_pkg::FuncTick);
  assign acc.rd    = advance & (req_q.func == mtr_pkg::FuncRead);
  assign acc.wr    = advance & (req_q.func == mtr_pkg::FuncWrite);
  assign acc.addr  = {req_q.addr[10:2], 2'b00};
  assign acc.wdata = req_q.wdata;

  assign glob_sel = acc.addr < mtr_pkg::AddrLocBase;

  mtr_global u_global (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .sel_i   (glob_sel),
    .rdata_o (glob_rdata),
    .irq_o   (glob_irq)
  );

  for (genvar g = 0; g < NUM_LOCAL; g++) begin : g_local
    localparam logic [2:0] Page = 3'((int'(mtr_pkg::AddrLocBase) >> 8) + g);

    assign loc_sel[g] = (acc.addr[10:8] == Page);

    mtr_local u_local (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .acc_i   (acc),
      .sel_i   (loc_sel[g]),
      .rdata_o (loc_rdata[g]),
      .irq_o   (loc_irq[g])
    );
  end

  for (genvar g = 0; g < mtr_pkg::LocalIrqW; g++) begin : g_irq
    if (g < NUM_LOCAL) begin : g_used
      assign loc_irq_all[g] = loc_irq[g];
    end else begin : g_unused
      assign loc_irq_all[g] = 1'b0;
    end
  end

  always_comb begin
    rsp.rdata = glob_rdata;
    for (int i = 0; i < NUM_LOCAL; i++) begin
      rsp.rdata = rsp.rdata | loc_rdata[i];
    end
    rsp.global_irq = glob_irq;
    rsp.local_irq  = loc_irq_all;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A held request with a stalled response stage must block new requests
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |-> !in_ready_o)
    else $error("request register overwritten while stalled");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request produced no response");

  a_irq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.local_irq >> NUM_LOCAL) == '0))
    else $error("interrupt raised for an absent local timer");

  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !acc.rd |=> out_q.rdata == '0)
    else $error("read data non-zero for a tick or write");

endmodule

`default_nettype wire
